>>> rtl/rbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types, constants and helpers for the routing block line parser.
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam logic [7:0] NUL_BYTE     = 8'd0;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] SPACE_BYTE   = 8'd32;
    localparam logic [7:0] TAB_BYTE     = 8'd9;
    localparam logic [7:0] VTAB_BYTE    = 8'd11;
    localparam logic [7:0] FF_BYTE      = 8'd12;
    localparam logic [7:0] CR_BYTE      = 8'd13;
    localparam logic [7:0] PLUS_BYTE    = 8'd43;
    localparam logic [7:0] MINUS_BYTE   = 8'd45;
    localparam logic [7:0] DIGIT0_BYTE  = 8'd48;
    localparam logic [7:0] DIGIT9_BYTE  = 8'd57;

    // Header text length ("VIDEO OUTPUT ROUTING:")
    localparam logic [4:0] HDR_LEN = 5'd21;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_INBLOCK = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        PH_BEFORE1 = 3'd0,
        PH_LEAD1   = 3'd1,
        PH_DIG1    = 3'd2,
        PH_JUNK1   = 3'd3,
        PH_BEFORE2 = 3'd4,
        PH_LEAD2   = 3'd5,
        PH_DIG2    = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    // Position within one number token
    typedef enum logic [1:0] {
        SUB_LEAD  = 2'd0,
        SUB_DIGIT = 2'd1,
        SUB_JUNK  = 2'd2
    } sub_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] dest;
        logic [7:0] source;
    } result_t;

    typedef struct packed {
        logic  line_empty;
        mode_t mode;
    } status_t;

    // Header character at a given position
    function automatic logic [7:0] hdr_char(input logic [4:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                5'd0:    ch = "V";
                5'd1:    ch = "I";
                5'd2:    ch = "D";
                5'd3:    ch = "E";
                5'd4:    ch = "O";
                5'd5:    ch = " ";
                5'd6:    ch = "O";
                5'd7:    ch = "U";
                5'd8:    ch = "T";
                5'd9:    ch = "P";
                5'd10:   ch = "U";
                5'd11:   ch = "T";
                5'd12:   ch = " ";
                5'd13:   ch = "R";
                5'd14:   ch = "O";
                5'd15:   ch = "U";
                5'd16:   ch = "T";
                5'd17:   ch = "I";
                5'd18:   ch = "N";
                5'd19:   ch = "G";
                5'd20:   ch = ":";
                default: ch = 8'd0;
            endcase
            return ch;
        end
    endfunction

    // acc * 10 +/- d, modulo 256
    function automatic logic [7:0] digit_step(input logic [7:0] acc, input logic [7:0] d,
                                              input logic neg);
        logic [7:0] t;
        begin
            t = {acc[4:0], 3'b000} + {acc[6:0], 1'b0};
            return neg ? (t - d) : (t + d);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/routing_block_line_parser_core.sv
`default_nettype none
// Routing block line parser core.
// An accepted byte is held in the input byte register and parsed when the parse stage
// advances; a resulting route word is registered and shows on out_valid.
// Throughput: one byte per cycle while no pending route word is held by out_stall.
// Reset: rst_n clears the mode to unknown, all per-line state and both valid flags.
// ----------------------------------------------------------------------------
// routing_block_line_parser_core
// Input byte register, line parser, and registered route word.
// ----------------------------------------------------------------------------
module routing_block_line_parser_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      route_dest,
    output logic [7:0]      route_source
);
    import rbp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic [7:0] dest_reg;
    logic [7:0] source_reg;

    logic       advance;
    logic       in_take;
    logic       proc_en;
    logic       load_result;
    result_t    res;
    status_t    st;

    // Handshake: parse stage moves when the output word is free or taken
    assign advance     = !out_valid_reg || !out_stall;
    assign in_stall    = in_valid_reg && !advance;
    assign in_take     = in_valid && !in_stall;
    assign proc_en     = in_valid_reg && advance;
    assign load_result = proc_en && res.valid;

    // Input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (proc_en)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= rx_byte;
    end

    rbp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (proc_en),
        .rx_byte (byte_reg),
        .result  (res),
        .status  (st)
    );

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= load_result;
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            dest_reg   <= res.dest;
            source_reg <= res.source;
        end
    end

    assign out_valid    = out_valid_reg;
    assign route_dest   = dest_reg;
    assign route_source = source_reg;

    // Checks
    a_result_on_newline: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |-> (byte_reg == NEWLINE_BYTE) && (st.mode == MODE_INBLOCK))
        else $error("route word produced from a non-newline byte or outside a block");

    a_newline_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && (byte_reg == NEWLINE_BYTE)) |=> st.line_empty)
        else $error("line state not cleared after newline");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |-> (!out_valid_reg || !out_stall))
        else $error("pending route word overwritten");

endmodule

`default_nettype wire

>>> rtl/rbp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbp_parser
// Per-line parse state: mode machine, header match and the two-number
// tokenizer. Advances by one byte whenever en is high.
// ----------------------------------------------------------------------------
module rbp_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic [7:0]      rx_byte,
    output rbp_pkg::result_t     result,
    output rbp_pkg::status_t     status
);
    import rbp_pkg::*;

    mode_t      mode_reg,       mode_next;
    logic [4:0] hdr_pos_reg,    hdr_pos_next;
    logic       hdr_match_reg,  hdr_match_next;
    logic       empty_reg,      empty_next;
    phase_t     phase_reg,      phase_next;
    logic       neg_reg,        neg_next;
    logic [7:0] first_reg,      first_next;
    logic [7:0] second_reg,     second_next;

    // Token helper signals
    logic       is_first;
    logic       is_digit;
    logic       is_lead;
    sub_t       sub_cur;
    sub_t       sub_new;
    logic [7:0] acc_cur;
    logic [7:0] acc_new;
    logic       neg_tok;
    logic       hdr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_UNKNOWN;
            hdr_pos_reg   <= 5'd0;
            hdr_match_reg <= 1'b1;
            empty_reg     <= 1'b1;
            phase_reg     <= PH_BEFORE1;
            neg_reg       <= 1'b0;
            first_reg     <= 8'd0;
            second_reg    <= 8'd0;
        end
        else if (en)
        begin
            mode_reg      <= mode_next;
            hdr_pos_reg   <= hdr_pos_next;
            hdr_match_reg <= hdr_match_next;
            empty_reg     <= empty_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
        end
    end

    // One token byte: lead skip, sign, digits, then junk
    always_comb
    begin
        is_first = (phase_reg == PH_BEFORE1) || (phase_reg == PH_LEAD1) ||
                   (phase_reg == PH_DIG1) || (phase_reg == PH_JUNK1);
        is_digit = (rx_byte >= DIGIT0_BYTE) && (rx_byte <= DIGIT9_BYTE);
        is_lead  = (rx_byte == TAB_BYTE) || (rx_byte == VTAB_BYTE) ||
                   (rx_byte == FF_BYTE) || (rx_byte == CR_BYTE);
        acc_cur  = is_first ? first_reg : second_reg;

        case (phase_reg)
            PH_DIG1, PH_DIG2:   sub_cur = SUB_DIGIT;
            PH_JUNK1, PH_DONE:  sub_cur = SUB_JUNK;
            default:            sub_cur = SUB_LEAD;
        endcase

        sub_new = SUB_JUNK;
        acc_new = acc_cur;
        neg_tok = neg_reg;
        case (sub_cur)
            SUB_LEAD:
            begin
                if (is_lead)
                    sub_new = SUB_LEAD;
                else if ((rx_byte == PLUS_BYTE) || (rx_byte == MINUS_BYTE))
                begin
                    neg_tok = (rx_byte == MINUS_BYTE);
                    sub_new = SUB_DIGIT;
                end
                else if (is_digit)
                begin
                    acc_new = digit_step(acc_cur, rx_byte - DIGIT0_BYTE, neg_reg);
                    sub_new = SUB_DIGIT;
                end
            end
            SUB_DIGIT:
            begin
                if (is_digit)
                begin
                    acc_new = digit_step(acc_cur, rx_byte - DIGIT0_BYTE, neg_reg);
                    sub_new = SUB_DIGIT;
                end
            end
            default:
                sub_new = SUB_JUNK;
        endcase
    end

    // Mode machine and per-line state
    always_comb
    begin
        mode_next      = mode_reg;
        hdr_pos_next   = hdr_pos_reg;
        hdr_match_next = hdr_match_reg;
        empty_next     = empty_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        result.valid   = 1'b0;
        result.dest    = first_reg;
        result.source  = second_reg;
        hdr_ok         = hdr_match_reg && (hdr_pos_reg >= HDR_LEN);

        if (rx_byte == NUL_BYTE)
        begin
            // zero byte: dropped
        end
        else if (rx_byte == NEWLINE_BYTE)
        begin
            unique case (mode_reg)
                MODE_WAIT:
                begin
                    if (hdr_ok)
                        mode_next = MODE_INBLOCK;
                end
                MODE_INBLOCK:
                begin
                    if (empty_reg)
                        mode_next = MODE_WAIT;
                    else
                        result.valid = 1'b1;
                end
                default:
                begin
                    if (empty_reg)
                        mode_next = MODE_WAIT;
                end
            endcase
            hdr_pos_next   = 5'd0;
            hdr_match_next = 1'b1;
            empty_next     = 1'b1;
            phase_next     = PH_BEFORE1;
            neg_next       = 1'b0;
            first_next     = 8'd0;
            second_next    = 8'd0;
        end
        else
        begin
            empty_next = 1'b0;
            if (hdr_pos_reg < HDR_LEN)
            begin
                if (rx_byte != hdr_char(hdr_pos_reg))
                    hdr_match_next = 1'b0;
                hdr_pos_next = hdr_pos_reg + 5'd1;
            end

            if (rx_byte == SPACE_BYTE)
            begin
                // space ends a token
                if ((phase_reg == PH_LEAD1) || (phase_reg == PH_DIG1) ||
                    (phase_reg == PH_JUNK1))
                begin
                    phase_next = PH_BEFORE2;
                    neg_next   = 1'b0;
                end
                else if ((phase_reg == PH_LEAD2) || (phase_reg == PH_DIG2) ||
                         (phase_reg == PH_DONE))
                    phase_next = PH_DONE;
            end
            else if (phase_reg != PH_DONE)
            begin
                neg_next = neg_tok;
                if (is_first)
                begin
                    first_next = acc_new;
                    case (sub_new)
                        SUB_LEAD:  phase_next = PH_LEAD1;
                        SUB_DIGIT: phase_next = PH_DIG1;
                        default:   phase_next = PH_JUNK1;
                    endcase
                end
                else
                begin
                    second_next = acc_new;
                    case (sub_new)
                        SUB_LEAD:  phase_next = PH_LEAD2;
                        SUB_DIGIT: phase_next = PH_DIG2;
                        default:   phase_next = PH_DONE;
                    endcase
                end
            end
        end
    end

    assign status.line_empty = empty_reg;
    assign status.mode       = mode_reg;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the routing block line parser against a cycle-free model of the
// line grammar: blank lines, the routing header, and number lines inside a
// block. Bytes go in under random sender gaps and receiver stalls, and every
// route word is compared field by field with the predicted queue.
// ----------------------------------------------------------------------------
module tb;
    import rbp_pkg::*;

    localparam int LONG_HOLD_CYCLES = 250;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_BYTES     = 1300;

    localparam logic [8*21-1:0] ROUTING_HEADER = "VIDEO OUTPUT ROUTING:";

    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] source;
    } route_word_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic [7:0] rx_byte      = 8'd0;
    logic       out_stall    = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] route_dest;
    logic [7:0] route_source;

    // Expected route words, oldest first
    route_word_t pending_routes[$];
    route_word_t next_route;
    int          mismatch_count = 0;
    int          bytes_sent     = 0;

    // Idle controls for the sender (send_idle_on) and the receiver (the rest)
    logic send_idle_on  = 1'b1;
    logic stall_enable  = 1'b1;
    logic hold_request  = 1'b0;
    int   stall_left    = 0;

    // Parser model state
    mode_t      pm_mode;
    logic [4:0] pm_hpos;
    logic       pm_hmatch;
    logic       pm_empty;
    phase_t     pm_phase;
    logic       pm_neg;
    logic [7:0] pm_dest;
    logic [7:0] pm_src;

    routing_block_line_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .route_dest   (route_dest),
        .route_source (route_source)
    );

    always #10 clk = ~clk;

    // Idle length: mostly short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] header_char(input int p);
        return ROUTING_HEADER[8*(20-p) +: 8];
    endfunction

    // acc * 10 with the digit added or taken away, modulo 256
    function automatic logic [7:0] accumulate_digit(input logic [7:0] acc,
                                                    input logic [7:0] c);
        logic [7:0] scaled;
        logic [7:0] d;
        scaled = acc * 8'd10;
        d = c - DIGIT0_BYTE;
        return pm_neg ? (scaled - d) : (scaled + d);
    endfunction

    task automatic clear_line();
        pm_hpos   = 5'd0;
        pm_hmatch = 1'b1;
        pm_empty  = 1'b1;
        pm_phase  = PH_BEFORE1;
        pm_neg    = 1'b0;
        pm_dest   = 8'd0;
        pm_src    = 8'd0;
    endtask

    // One non-space byte inside a number token
    task automatic scan_token(inout sub_t sub, input logic [7:0] c, inout logic [7:0] acc);
        logic is_digit;
        is_digit = (c >= DIGIT0_BYTE) && (c <= DIGIT9_BYTE);
        case (sub)
            SUB_LEAD:
            begin
                if (c == TAB_BYTE || c == VTAB_BYTE || c == FF_BYTE || c == CR_BYTE)
                    sub = SUB_LEAD;
                else if (c == PLUS_BYTE || c == MINUS_BYTE)
                begin
                    pm_neg = (c == MINUS_BYTE);
                    sub = SUB_DIGIT;
                end
                else if (is_digit)
                begin
                    acc = accumulate_digit(acc, c);
                    sub = SUB_DIGIT;
                end
                else
                    sub = SUB_JUNK;
            end
            SUB_DIGIT:
            begin
                if (is_digit)
                    acc = accumulate_digit(acc, c);
                else
                    sub = SUB_JUNK;
            end
            default:
                sub = SUB_JUNK;
        endcase
    endtask

    // Advance the parser model by one accepted byte
    task automatic predict_byte(input logic [7:0] c);
        logic        at_header;
        logic        first_tok;
        sub_t        sub;
        route_word_t w;
        if (c == NEWLINE_BYTE)
        begin
            at_header = pm_hmatch && (pm_hpos >= HDR_LEN);
            case (pm_mode)
                MODE_WAIT:
                    if (at_header)
                        pm_mode = MODE_INBLOCK;
                MODE_INBLOCK:
                begin
                    if (pm_empty)
                        pm_mode = MODE_WAIT;
                    else
                    begin
                        w.dest   = pm_dest;
                        w.source = pm_src;
                        pending_routes.push_back(w);
                    end
                end
                default:
                    if (pm_empty)
                        pm_mode = MODE_WAIT;
            endcase
            clear_line();
        end
        else if (c != NUL_BYTE)
        begin
            pm_empty = 1'b0;
            if (pm_hpos < HDR_LEN)
            begin
                if (c != header_char(pm_hpos))
                    pm_hmatch = 1'b0;
                pm_hpos = pm_hpos + 5'd1;
            end
            if (c == SPACE_BYTE)
            begin
                // a space ends a token that has started
                if (pm_phase == PH_LEAD1 || pm_phase == PH_DIG1 || pm_phase == PH_JUNK1)
                begin
                    pm_phase = PH_BEFORE2;
                    pm_neg   = 1'b0;
                end
                else if (pm_phase == PH_LEAD2 || pm_phase == PH_DIG2)
                    pm_phase = PH_DONE;
            end
            else
            begin
                first_tok = (pm_phase <= PH_JUNK1);
                case (pm_phase)
                    PH_BEFORE1, PH_LEAD1, PH_BEFORE2, PH_LEAD2: sub = SUB_LEAD;
                    PH_DIG1, PH_DIG2:                           sub = SUB_DIGIT;
                    default:                                    sub = SUB_JUNK;
                endcase
                if (first_tok)
                begin
                    scan_token(sub, c, pm_dest);
                    pm_phase = (sub == SUB_LEAD) ? PH_LEAD1 :
                               (sub == SUB_DIGIT) ? PH_DIG1 : PH_JUNK1;
                end
                else
                begin
                    scan_token(sub, c, pm_src);
                    pm_phase = (sub == SUB_LEAD) ? PH_LEAD2 :
                               (sub == SUB_DIGIT) ? PH_DIG2 : PH_DONE;
                end
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
        end
        else if (stall_left == 0 && stall_enable && $urandom_range(0, 3) == 0)
            stall_left = idle_length();
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted route word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_routes.size() == 0)
            begin
                $error("unexpected route word: dest %0d, source %0d", route_dest, route_source);
                mismatch_count++;
            end
            else
            begin
                next_route = pending_routes.pop_front();
                if (route_dest !== next_route.dest)
                begin
                    $error("route_dest: expected %0d, got %0d", next_route.dest, route_dest);
                    mismatch_count++;
                end
                if (route_source !== next_route.source)
                begin
                    $error("route_source: expected %0d, got %0d", next_route.source,
                           route_source);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one byte and wait for it to be taken
    task automatic send_byte(input logic [7:0] b);
        if (send_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_length()) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        predict_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Byte inside a line, now and then preceded by a stray zero byte
    task automatic send_line_byte(input logic [7:0] b);
        if ($urandom_range(0, 49) == 0)
            send_byte(NUL_BYTE);
        send_byte(b);
    endtask

    task automatic send_token();
        int         n_digits;
        int         r;
        logic [7:0] ch;
        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                case ($urandom_range(0, 3))
                    0:       send_line_byte(TAB_BYTE);
                    1:       send_line_byte(VTAB_BYTE);
                    2:       send_line_byte(FF_BYTE);
                    default: send_line_byte(CR_BYTE);
                endcase
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_line_byte($urandom_range(0, 1) ? MINUS_BYTE : PLUS_BYTE);
        r = $urandom_range(0, 19);
        n_digits = (r == 0) ? 0 : (r < 14) ? $urandom_range(1, 3) : $urandom_range(4, 6);
        repeat (n_digits)
            send_line_byte(DIGIT0_BYTE + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0)
        begin
            ch = 8'($urandom_range(33, 126));
            if (ch >= DIGIT0_BYTE && ch <= DIGIT9_BYTE)
                ch = "x";
            send_line_byte(ch);
        end
    endtask

    // Number line; the separator is always sent, so it is never blank
    task automatic send_route_line();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) send_line_byte(SPACE_BYTE);
        if ($urandom_range(0, 19) != 0)
            send_token();
        repeat ($urandom_range(0, 4) == 0 ? 2 : 1) send_line_byte(SPACE_BYTE);
        if ($urandom_range(0, 11) != 0)
            send_token();
        if ($urandom_range(0, 6) == 0)
        begin
            send_line_byte(SPACE_BYTE);
            repeat ($urandom_range(1, 4)) send_line_byte(8'($urandom_range(33, 126)));
        end
        send_byte(NEWLINE_BYTE);
    endtask

    // Header line, sometimes cut short, damaged or followed by text
    task automatic send_header_line();
        int         cut;
        int         bad_pos;
        logic [7:0] ch;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 21;
        bad_pos = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 20) : -1;
        for (int p = 0; p < cut; p++)
        begin
            ch = header_char(p);
            if (p == bad_pos)
                ch = ch ^ (8'd1 << $urandom_range(0, 6));
            send_line_byte(ch);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) send_line_byte(8'($urandom_range(32, 126)));
        send_byte(NEWLINE_BYTE);
    endtask

    // Arbitrary bytes up to a newline; length zero makes a blank line
    task automatic send_noise_line();
        logic [7:0] ch;
        repeat ($urandom_range(0, 6))
        begin
            ch = 8'($urandom_range(0, 255));
            if (ch == NEWLINE_BYTE)
                ch = 8'($urandom_range(128, 255));
            send_byte(ch);
        end
        send_byte(NEWLINE_BYTE);
    endtask

    // Sender goes quiet until every expected route word has come back
    task automatic wait_for_routes();
        in_valid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Unknown to wait on a blank line only; short header and zero byte
    task automatic test_block_entry();
        send_byte(CR_BYTE);
        send_byte(NEWLINE_BYTE);
        send_text("\n");
        send_text("VIDEO\n");
        send_byte(NUL_BYTE);
        send_text("VIDEO OUTPUT ROUTING:\n");
    endtask

    // Extremes, signs, lead bytes, junk, missing numbers, lone carriage return
    task automatic test_number_forms();
        send_text("255 0\n");
        send_text("-1 +300\n");
        send_byte(TAB_BYTE);
        send_byte(CR_BYTE);
        send_text("9z 12 77\n");
        send_text("- +\n");
        send_text("5\n");
        send_text("  \n");
        send_byte(CR_BYTE);
        send_byte(NEWLINE_BYTE);
    endtask

    // Full output side: the receiver holds while the sender keeps going
    task automatic test_output_backpressure();
        send_idle_on = 1'b0;
        hold_request = 1'b1;
        repeat (30) send_route_line();
        send_idle_on = 1'b1;
        wait_for_routes();
    endtask

    // Blank line leaves the block; number lines outside give nothing
    task automatic test_block_exit();
        send_text("\n");
        send_text("1 2\n");
    endtask

    // Mostly well-formed traffic steered by the model's mode
    task automatic test_random_stream();
        int stop_at;
        int r;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_idle_on = ($urandom_range(0, 2) != 0);
                stall_enable = ($urandom_range(0, 2) != 0);
            end
            r = $urandom_range(0, 99);
            if (pm_mode == MODE_INBLOCK)
            begin
                if (r < 84)
                    send_route_line();
                else if (r < 92)
                    send_byte(NEWLINE_BYTE);
                else
                    send_noise_line();
            end
            else
            begin
                if (r < 55)
                    send_header_line();
                else if (r < 80)
                    send_byte(NEWLINE_BYTE);
                else
                    send_noise_line();
            end
        end
        stall_enable = 1'b1;
    endtask

    // Main sequence
    initial
    begin
        pm_mode = MODE_UNKNOWN;
        clear_line();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_block_entry();
        test_number_forms();
        test_output_backpressure();
        test_block_exit();
        test_random_stream();
        wait_for_routes();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
